// ===== src/rsdb_pkg.sv =====
// Package for the RRIP replacement engine with signature bypass and set dueling.
// Holds sizes, field layouts, memory request types, state codes and hash functions.
// No dependencies.
`timescale 1ns / 1ps

package rsdb_pkg;

    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int SIG_ENTRIES = 4096;
    localparam int FILTER_BITS = 8192;
    localparam int DUEL_BITS   = 10;

    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int SIG_W    = $clog2(SIG_ENTRIES);
    localparam int FLT_W    = $clog2(FILTER_BITS);
    localparam int SWEEP_W  = FLT_W + 1;
    localparam int ADDR_W   = 64;
    localparam int LADDR_W  = 58;
    localparam int STRIDE_W = 59;
    localparam int RUN_W    = 8;
    localparam int RRPV_W   = 3;
    localparam int CTR_W    = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [RRPV_W-1:0] RRPV_FAR    = 3'd7;
    localparam logic [RRPV_W-1:0] RRPV_HOT    = 3'd0;
    localparam logic [RRPV_W-1:0] RRPV_STREAM = 3'd5;
    localparam logic [RRPV_W-1:0] RRPV_DEF    = 3'd6;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;
    localparam logic [31:0] HASH_XOR = 32'h0000dead;

    localparam int LEAD_W      = 6;
    localparam int LEADER_SIZE = 8;

    localparam logic [DUEL_BITS-1:0] DUEL_MAX = {DUEL_BITS{1'b1}};
    localparam logic [DUEL_BITS-1:0] DUEL_MID = DUEL_MAX >> 1;

    localparam logic REQ_QUERY  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL   = 3'd0,
        CFG_HOT        = 3'd1,
        CFG_DEAD       = 3'd2,
        CFG_RUN_MIN    = 3'd3,
        CFG_MAX_STRIDE = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECAY,
        ST_RD0,
        ST_RD1,
        ST_EXEC,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [RRPV_W-1:0] rrpv;
        logic [SIG_W-1:0]  sig;
        logic              reused;
    } t_line_ent;

    typedef t_line_ent [NUM_WAYS-1:0] t_line_row;

    typedef struct packed {
        logic [CTR_W-1:0] reuse;
        logic [CTR_W-1:0] dead;
    } t_cnt_ent;

    typedef struct packed {
        logic                valid;
        logic [LADDR_W-1:0]  addr;
        logic [STRIDE_W-1:0] stride;
        logic [RUN_W-1:0]    run;
    } t_str_ent;

    typedef struct packed {
        logic [SET_W-1:0] line_raddr;
        logic             line_we;
        logic [SET_W-1:0] line_waddr;
        t_line_row        line_wdata;
        logic [SIG_W-1:0] cnt_raddr_a;
        logic [SIG_W-1:0] cnt_raddr_b;
        logic             cnt_we;
        logic [SIG_W-1:0] cnt_waddr;
        t_cnt_ent         cnt_wdata;
        logic [SIG_W-1:0] str_raddr;
        logic             str_we;
        logic [SIG_W-1:0] str_waddr;
        t_str_ent         str_wdata;
        logic [FLT_W-1:0] blm_raddr_a;
        logic [FLT_W-1:0] blm_raddr_b;
        logic             blm_we;
        logic [FLT_W-1:0] blm_waddr;
        logic             blm_wdata;
    } t_mem_req;

    typedef struct packed {
        t_line_row line_rdata;
        t_cnt_ent  cnt_rdata_a;
        t_cnt_ent  cnt_rdata_b;
        t_str_ent  str_rdata;
        logic      blm_rdata_a;
        logic      blm_rdata_b;
    } t_mem_rsp;

    function automatic logic [FLT_W-1:0] hash_a(input logic [SIG_W-1:0] sig);
        logic [31:0] p;
        p = 32'(sig) * HASH_MUL;
        return p[FLT_W-1:0];
    endfunction

    function automatic logic [FLT_W-1:0] hash_b(input logic [SIG_W-1:0] sig);
        logic [31:0] p;
        p = (32'(sig) ^ HASH_XOR) * HASH_MUL;
        return p[FLT_W-1:0];
    endfunction

endpackage

// ===== src/rsdb_store.sv =====
// State memories of the replacement engine: line table, signature counters,
// stride table and Bloom filter, each with a registered read.
// Depends on rsdb_pkg.
`timescale 1ns / 1ps

module rsdb_store import rsdb_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_mem_req,
    output t_mem_rsp o_mem_rsp
);

    t_line_row         r_line_mem [NUM_SETS];
    t_cnt_ent          r_cnt_mem  [SIG_ENTRIES];
    t_str_ent          r_str_mem  [SIG_ENTRIES];
    logic              r_blm_mem  [FILTER_BITS];

    always_ff @(posedge i_clk) begin
        if (i_mem_req.line_we) begin
            r_line_mem[i_mem_req.line_waddr] <= i_mem_req.line_wdata;
        end
        o_mem_rsp.line_rdata <= r_line_mem[i_mem_req.line_raddr];

        if (i_mem_req.cnt_we) begin
            r_cnt_mem[i_mem_req.cnt_waddr] <= i_mem_req.cnt_wdata;
        end
        o_mem_rsp.cnt_rdata_a <= r_cnt_mem[i_mem_req.cnt_raddr_a];
        o_mem_rsp.cnt_rdata_b <= r_cnt_mem[i_mem_req.cnt_raddr_b];

        if (i_mem_req.str_we) begin
            r_str_mem[i_mem_req.str_waddr] <= i_mem_req.str_wdata;
        end
        o_mem_rsp.str_rdata <= r_str_mem[i_mem_req.str_raddr];

        if (i_mem_req.blm_we) begin
            r_blm_mem[i_mem_req.blm_waddr] <= i_mem_req.blm_wdata;
        end
        o_mem_rsp.blm_rdata_a <= r_blm_mem[i_mem_req.blm_raddr_a];
        o_mem_rsp.blm_rdata_b <= r_blm_mem[i_mem_req.blm_raddr_b];
    end

endmodule

// ===== src/rsdb_ctrl.sv =====
// Sequencer and datapath of the replacement engine: handshakes, configuration,
// clearing and decay sweeps, and the read-modify-write of every item.
// Depends on rsdb_pkg; drives the memories in rsdb_store.
`timescale 1ns / 1ps

module rsdb_ctrl import rsdb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [SET_W-1:0]      i_set_index,
    input  logic [WAY_W-1:0]      i_way_index,
    input  logic [ADDR_W-1:0]     i_phys_addr,
    input  logic [ADDR_W-1:0]     i_prog_counter,
    input  logic                  i_was_hit,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [WAY_W-1:0]      o_victim_way,
    output logic [RRPV_W-1:0]     o_inserted_rrpv,
    output logic                  o_bypassed,
    output t_mem_req              o_mem_req,
    input  t_mem_rsp              i_mem_rsp
);

    t_state               r_state, n_state;
    logic [SWEEP_W-1:0]   r_sweep, n_sweep;
    logic [5:0]           r_cfg_k;
    logic [CTR_W-1:0]     r_hot_thr;
    logic [CTR_W-1:0]     r_dead_thr;
    logic [RUN_W-1:0]     r_run_min;
    logic [7:0]           r_max_stride;
    logic [31:0]          r_access;
    logic [DUEL_BITS-1:0] r_duel;

    logic                 r_req;
    logic [SET_W-1:0]     r_set;
    logic [WAY_W-1:0]     r_way;
    logic [LADDR_W-1:0]   r_laddr;
    logic [SIG_W-1:0]     r_sig;
    logic                 r_hit;
    logic                 r_lead_a;
    logic                 r_lead_b;
    logic [FLT_W-1:0]     r_sig_ha;
    logic [FLT_W-1:0]     r_sig_hb;
    t_line_ent            r_old;
    logic [FLT_W-1:0]     r_old_ha;
    logic [FLT_W-1:0]     r_old_hb;
    logic [WAY_W-1:0]     r_res_victim;
    logic [RRPV_W-1:0]    r_res_rrpv;
    logic                 r_res_byp;
    logic                 r_blm2_we;
    logic [FLT_W-1:0]     r_blm2_addr;
    logic                 r_out_valid;
    logic [WAY_W-1:0]     r_out_victim;
    logic [RRPV_W-1:0]    r_out_rrpv;
    logic                 r_out_byp;

    logic                 w_accept;
    logic                 w_out_free;
    logic [31:0]          w_cnt_next;
    logic [5:0]           w_k;
    logic [32:0]          w_mask;
    logic                 w_decay;
    logic [LEAD_W-1:0]    w_lead;
    logic                 w_lead_a;
    logic                 w_lead_b;
    logic [SIG_W-1:0]     w_pc_sig;
    t_line_row            w_row;
    t_line_ent            w_live;
    t_line_row            w_clear_row;

    logic [7:0]           w_has;
    logic [RRPV_W-1:0]    w_maxv;
    logic [WAY_W-1:0]     w_pick;
    t_line_row            w_aged_row;

    logic                 w_train;
    t_cnt_ent             w_cnt_old;
    t_cnt_ent             w_cnt_sig;
    logic                 w_bloom_a;
    logic                 w_bloom_b;
    t_str_ent             w_str_old;
    t_str_ent             w_str_new;
    logic [STRIDE_W-1:0]  w_st;
    logic [STRIDE_W-1:0]  w_inv;
    logic                 w_small;
    logic                 w_stream;
    logic                 w_policy;
    logic                 w_dead;
    logic [RRPV_W-1:0]    w_rrpv;
    logic                 w_byp;
    t_line_row            w_upd_row;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    assign w_cnt_next = r_access + 32'd1;
    assign w_k        = (r_cfg_k == 6'd0) ? 6'd1 : ((r_cfg_k > 6'd32) ? 6'd32 : r_cfg_k);
    assign w_mask     = (33'd1 << w_k) - 33'd1;
    assign w_decay    = ((w_cnt_next & w_mask[31:0]) == 32'd0);
    assign w_lead     = i_set_index[LEAD_W-1:0];
    assign w_lead_a   = (w_lead < LEAD_W'(LEADER_SIZE));
    assign w_lead_b   = !w_lead_a && (w_lead < LEAD_W'(2 * LEADER_SIZE));
    assign w_pc_sig   = i_prog_counter[2 +: SIG_W] ^ i_prog_counter[12 +: SIG_W];

    assign w_row  = i_mem_rsp.line_rdata;
    assign w_live = w_row[r_way];

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_clear_row[w] = '{rrpv: RRPV_FAR, sig: '0, reused: 1'b0};
        end
    end

    // Victim search and aging over the set.
    always_comb begin
        w_has  = '0;
        w_maxv = '0;
        w_pick = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_has[w_row[w].rrpv] = 1'b1;
        end
        for (int v = 0; v < 8; v++) begin
            if (w_has[v]) begin
                w_maxv = RRPV_W'(v);
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_row[w].rrpv == w_maxv) begin
                w_pick = WAY_W'(w);
            end
        end
        w_aged_row = w_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_aged_row[w].rrpv = w_row[w].rrpv + (RRPV_FAR - w_maxv);
        end
    end

    // Training, stride tracking and insertion choice for an update.
    always_comb begin
        w_train   = !r_old.reused;
        w_cnt_old = i_mem_rsp.cnt_rdata_a;
        if (r_hit) begin
            if (w_cnt_old.reuse != 2'd3) begin
                w_cnt_old.reuse = w_cnt_old.reuse + 2'd1;
            end
            w_cnt_old.dead = '0;
        end else begin
            if (w_cnt_old.dead != 2'd3) begin
                w_cnt_old.dead = w_cnt_old.dead + 2'd1;
            end
            if (w_cnt_old.reuse != 2'd0) begin
                w_cnt_old.reuse = w_cnt_old.reuse - 2'd1;
            end
        end
        w_cnt_sig = (w_train && (r_old.sig == r_sig)) ? w_cnt_old : i_mem_rsp.cnt_rdata_b;
        w_bloom_a = i_mem_rsp.blm_rdata_a ||
                    (w_train && ((r_sig_ha == r_old_ha) || (r_sig_ha == r_old_hb)));
        w_bloom_b = i_mem_rsp.blm_rdata_b ||
                    (w_train && ((r_sig_hb == r_old_ha) || (r_sig_hb == r_old_hb)));

        w_str_old = i_mem_rsp.str_rdata;
        w_st      = {1'b0, r_laddr} - {1'b0, w_str_old.addr};
        w_str_new = w_str_old;
        if (w_str_old.valid) begin
            if (w_st == w_str_old.stride) begin
                w_str_new.run = w_str_old.run + 8'd1;
            end else begin
                w_str_new.stride = w_st;
                w_str_new.run    = 8'd1;
            end
        end else begin
            w_str_new.stride = '0;
            w_str_new.run    = 8'd1;
        end
        w_str_new.addr  = r_laddr;
        w_str_new.valid = 1'b1;

        w_inv = ~w_str_new.stride;
        if (!w_str_new.stride[STRIDE_W-1]) begin
            w_small = (w_str_new.stride[STRIDE_W-2:8] == '0) &&
                      (w_str_new.stride[7:0] <= r_max_stride);
        end else begin
            w_small = (w_inv[STRIDE_W-2:8] == '0) && (w_inv[7:0] < r_max_stride);
        end
        w_stream = w_str_old.valid && (w_str_new.run >= r_run_min) && w_small;

        if (r_lead_a) begin
            w_policy = 1'b1;
        end else if (r_lead_b) begin
            w_policy = 1'b0;
        end else begin
            w_policy = (r_duel > DUEL_MID);
        end
        w_dead = (w_bloom_a && w_bloom_b) || (w_cnt_sig.dead >= r_dead_thr);

        w_byp = 1'b0;
        if (r_hit) begin
            w_rrpv = RRPV_HOT;
        end else if (w_dead) begin
            w_rrpv = RRPV_FAR;
            w_byp  = 1'b1;
        end else if (w_policy && (w_cnt_sig.reuse >= r_hot_thr)) begin
            w_rrpv = RRPV_HOT;
        end else if (w_policy && w_stream) begin
            w_rrpv = RRPV_STREAM;
        end else begin
            w_rrpv = RRPV_DEF;
        end

        w_upd_row = w_row;
        if (r_hit) begin
            w_upd_row[r_way] = '{rrpv: RRPV_HOT, sig: r_old.sig, reused: 1'b1};
        end else begin
            w_upd_row[r_way] = '{rrpv: w_rrpv, sig: r_sig, reused: 1'b0};
        end
    end

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        o_mem_req = '0;
        o_mem_req.line_raddr  = r_set;
        o_mem_req.str_raddr   = r_sig;
        o_mem_req.cnt_raddr_a = w_live.sig;
        o_mem_req.cnt_raddr_b = r_sig;
        o_mem_req.blm_raddr_a = r_sig_ha;
        o_mem_req.blm_raddr_b = r_sig_hb;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_req.line_we    = (r_sweep < SWEEP_W'(NUM_SETS));
                o_mem_req.line_waddr = r_sweep[SET_W-1:0];
                o_mem_req.line_wdata = w_clear_row;
                o_mem_req.cnt_we     = (r_sweep < SWEEP_W'(SIG_ENTRIES));
                o_mem_req.cnt_waddr  = r_sweep[SIG_W-1:0];
                o_mem_req.cnt_wdata  = '{reuse: 2'd1, dead: 2'd0};
                o_mem_req.str_we     = (r_sweep < SWEEP_W'(SIG_ENTRIES));
                o_mem_req.str_waddr  = r_sweep[SIG_W-1:0];
                o_mem_req.blm_we     = 1'b1;
                o_mem_req.blm_waddr  = r_sweep[FLT_W-1:0];
                n_sweep = r_sweep + SWEEP_W'(1);
                if (r_sweep == SWEEP_W'(FILTER_BITS - 1)) begin
                    n_sweep = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_sweep = '0;
                    if (i_req_type == REQ_UPDATE && w_decay) begin
                        n_state = ST_DECAY;
                    end else begin
                        n_state = ST_RD0;
                    end
                end
            end
            ST_DECAY: begin
                o_mem_req.cnt_raddr_a = r_sweep[SIG_W-1:0];
                o_mem_req.blm_we      = (r_sweep < SWEEP_W'(FILTER_BITS));
                o_mem_req.blm_waddr   = r_sweep[FLT_W-1:0];
                o_mem_req.cnt_we      = (r_sweep != '0) && (r_sweep <= SWEEP_W'(SIG_ENTRIES));
                o_mem_req.cnt_waddr   = SIG_W'(r_sweep - SWEEP_W'(1));
                o_mem_req.cnt_wdata   = '{reuse: i_mem_rsp.cnt_rdata_a.reuse >> 1, dead: 2'd0};
                n_sweep = r_sweep + SWEEP_W'(1);
                if (r_sweep == SWEEP_W'(FILTER_BITS)) begin
                    n_sweep = '0;
                    n_state = ST_RD0;
                end
            end
            ST_RD0: begin
                n_state = ST_RD1;
            end
            ST_RD1: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                o_mem_req.line_we    = 1'b1;
                o_mem_req.line_waddr = r_set;
                if (r_req == REQ_QUERY) begin
                    o_mem_req.line_wdata = w_aged_row;
                end else begin
                    o_mem_req.line_wdata = w_upd_row;
                    o_mem_req.cnt_we     = w_train;
                    o_mem_req.cnt_waddr  = r_old.sig;
                    o_mem_req.cnt_wdata  = w_cnt_old;
                    o_mem_req.str_we     = !r_hit;
                    o_mem_req.str_waddr  = r_sig;
                    o_mem_req.str_wdata  = w_str_new;
                    o_mem_req.blm_we     = !r_hit && w_train;
                    o_mem_req.blm_waddr  = r_old_ha;
                    o_mem_req.blm_wdata  = 1'b1;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                o_mem_req.blm_we    = r_blm2_we;
                o_mem_req.blm_waddr = r_blm2_addr;
                o_mem_req.blm_wdata = 1'b1;
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_sweep      <= '0;
            r_cfg_k      <= 6'd20;
            r_hot_thr    <= 2'd2;
            r_dead_thr   <= 2'd3;
            r_run_min    <= 8'd2;
            r_max_stride <= 8'd8;
            r_access     <= '0;
            r_duel       <= DUEL_MID;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INTERVAL:   r_cfg_k      <= i_cfg_data[5:0];
                    CFG_HOT:        r_hot_thr    <= i_cfg_data[CTR_W-1:0];
                    CFG_DEAD:       r_dead_thr   <= i_cfg_data[CTR_W-1:0];
                    CFG_RUN_MIN:    r_run_min    <= i_cfg_data;
                    CFG_MAX_STRIDE: r_max_stride <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept && i_req_type == REQ_UPDATE) begin
                r_access <= w_cnt_next;
                if (w_lead_a) begin
                    if (i_was_hit && r_duel != DUEL_MAX) begin
                        r_duel <= r_duel + DUEL_BITS'(1);
                    end else if (!i_was_hit && r_duel != '0) begin
                        r_duel <= r_duel - DUEL_BITS'(1);
                    end
                end else if (w_lead_b) begin
                    if (!i_was_hit && r_duel != DUEL_MAX) begin
                        r_duel <= r_duel + DUEL_BITS'(1);
                    end else if (i_was_hit && r_duel != '0) begin
                        r_duel <= r_duel - DUEL_BITS'(1);
                    end
                end
            end
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= i_req_type;
            r_set    <= i_set_index;
            r_way    <= i_way_index;
            r_laddr  <= i_phys_addr[ADDR_W-1:ADDR_W-LADDR_W];
            r_sig    <= w_pc_sig;
            r_hit    <= i_was_hit;
            r_lead_a <= w_lead_a;
            r_lead_b <= w_lead_b;
            r_sig_ha <= hash_a(w_pc_sig);
            r_sig_hb <= hash_b(w_pc_sig);
        end
        if (r_state == ST_RD1) begin
            r_old    <= w_live;
            r_old_ha <= hash_a(w_live.sig);
            r_old_hb <= hash_b(w_live.sig);
        end
        if (r_state == ST_EXEC) begin
            if (r_req == REQ_QUERY) begin
                r_res_victim <= w_pick;
                r_res_rrpv   <= '0;
                r_res_byp    <= 1'b0;
                r_blm2_we    <= 1'b0;
            end else begin
                r_res_victim <= '0;
                r_res_rrpv   <= w_rrpv;
                r_res_byp    <= w_byp;
                r_blm2_we    <= !r_hit && w_train;
            end
            r_blm2_addr <= r_old_hb;
        end
        if (r_state == ST_FIN && w_out_free) begin
            r_out_victim <= r_res_victim;
            r_out_rrpv   <= r_res_rrpv;
            r_out_byp    <= r_res_byp;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_victim_way    = r_out_victim;
    assign o_inserted_rrpv = r_out_rrpv;
    assign o_bypassed      = r_out_byp;

endmodule

// ===== src/rrip_ship_dueling_bypass_replacement.sv =====
// Top level of the RRIP replacement engine with signature bypass and set dueling.
// Depends on rsdb_pkg, rsdb_ctrl and rsdb_store.
//
// Each item is a victim query or an access update and gives one result item. No new
// item is accepted until the current one has passed the states RD0, RD1, EXEC and
// FIN (read, read, modify and write-back over the set and signature memories); FIN
// holds while the result is stalled. An update that reaches the decay interval
// first walks the Bloom filter and signature counters. After reset a clearing pass
// runs before the first item is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps

module rrip_ship_dueling_bypass_replacement import rsdb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [SET_W-1:0]      i_set_index,
    input  logic [WAY_W-1:0]      i_way_index,
    input  logic [ADDR_W-1:0]     i_phys_addr,
    input  logic [ADDR_W-1:0]     i_prog_counter,
    input  logic                  i_was_hit,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [WAY_W-1:0]      o_victim_way,
    output logic [RRPV_W-1:0]     o_inserted_rrpv,
    output logic                  o_bypassed
);

    t_mem_req w_mem_req;
    t_mem_rsp w_mem_rsp;

    rsdb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_set_index     (i_set_index),
        .i_way_index     (i_way_index),
        .i_phys_addr     (i_phys_addr),
        .i_prog_counter  (i_prog_counter),
        .i_was_hit       (i_was_hit),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_victim_way    (o_victim_way),
        .o_inserted_rrpv (o_inserted_rrpv),
        .o_bypassed      (o_bypassed),
        .o_mem_req       (w_mem_req),
        .i_mem_rsp       (w_mem_rsp)
    );

    rsdb_store u_store (
        .i_clk     (i_clk),
        .i_mem_req (w_mem_req),
        .o_mem_rsp (w_mem_rsp)
    );

endmodule

// ===== src/rsdb_checker.sv =====
// Port-level checks for the replacement engine, bound to the top level.
// Depends on rsdb_pkg and rrip_ship_dueling_bypass_replacement.
`timescale 1ns / 1ps

module rsdb_checker import rsdb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [WAY_W-1:0]  o_victim_way,
    input logic [RRPV_W-1:0] o_inserted_rrpv,
    input logic              o_bypassed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_victim_way) &&
        $stable(o_inserted_rrpv) && $stable(o_bypassed))
        else $error("Stalled result item changed.");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("Input taken during the clearing pass.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Second item taken while one is at work.");

    a_bypass_rrpv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bypassed |-> o_inserted_rrpv == RRPV_FAR && o_victim_way == '0)
        else $error("Bypassed item not inserted at the distant RRPV.");

    a_update_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inserted_rrpv != '0 |-> o_victim_way == '0)
        else $error("Update result carries a victim way.");

endmodule

bind rrip_ship_dueling_bypass_replacement rsdb_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_victim_way    (o_victim_way),
    .o_inserted_rrpv (o_inserted_rrpv),
    .o_bypassed      (o_bypassed)
);
